FILE: src/dtmd_pkg.sv
// dtmd_pkg: shared widths, constants, sequencer states and arithmetic helpers
// for the dual-tap modulated delay; no dependencies
package dtmd_pkg;

  // field widths
  localparam int DATA_W = 16;
  localparam int MOD_W  = 16;
  localparam int LEN_W  = 12;

  // q15 fraction bits and derived datapath widths
  localparam int Q15_W = 15;
  localparam int PW    = MOD_W + LEN_W;   // displacement mod*offset
  localparam int WGT_W = Q15_W + 3;       // interpolation weights, signed
  localparam int ACC_W = DATA_W + WGT_W;  // product and two-term sum

  // store size and length register
  localparam int DEPTH_DEFAULT = 2048;
  localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(10);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(2048);

  localparam logic signed [WGT_W-1:0] Q15_ONE = WGT_W'(32768);

  // read phase: four taps issued, then the multiply/accumulate drains
  localparam logic [2:0] RD_CNT_LAST = 3'd5;
  localparam logic [2:0] RD_CNT_TAPS = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INDEX,
    ST_READ,
    ST_ROUND
  } dtmd_state_t;

  // written length saturated into the usable range of the store
  function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len,
                                                  input int unsigned depth);
    logic [LEN_W-1:0] r;
    if (len < LEN_MIN) begin
      r = LEN_MIN;
    end else if (32'(len) > depth) begin
      r = LEN_W'(depth);
    end else begin
      r = len;
    end
    return r;
  endfunction

  // q15 accumulator to sample: round half away from zero, saturate
  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] q;
    logic signed [DATA_W-1:0] r;
    mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    q   = (mag + ACC_W'(16384)) >> Q15_W;
    if (!acc[ACC_W-1]) begin
      r = (q > ACC_W'(32767)) ? 16'sh7fff : $signed(q[DATA_W-1:0]);
    end else begin
      r = (q > ACC_W'(32768)) ? 16'sh8000 : $signed(DATA_W'(-q));
    end
    return r;
  endfunction

endpackage

FILE: src/dtmd_ram.sv
// dtmd_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module dtmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/dual_tap_modulated_delay.sv
// dual_tap_modulated_delay: circular delay store with two modulated,
// linearly interpolated taps; uses dtmd_pkg and dtmd_ram
// one item at a time: a new sample is taken only when idle, after the index step,
// four tap reads on one ram port, the multiply/accumulate drain and rounding
// reset (synchronous): length 2048, write pointer zero, store reads as zero;
// never-written entries are masked by written-region tracking, no clearing pass
module dual_tap_modulated_delay
  import dtmd_pkg::*;
#(
  parameter int DELAY_DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] audio_in,
  input  logic signed [MOD_W-1:0]  mod_left,
  input  logic signed [MOD_W-1:0]  mod_right,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] tap_left,
  output logic signed [DATA_W-1:0] tap_right,
  // length register write
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [LEN_W-1:0]         cfg_data
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int XW = ((AW > LEN_W) ? AW : LEN_W) + 2;
  localparam logic signed [XW-1:0] ONE_X = XW'(1);

  dtmd_state_t state, state_next;

  logic [2:0]        cnt;
  logic [AW-1:0]     wp;
  logic              wrapped;
  logic [LEN_W-1:0]  len_eff;

  logic signed [PW-1:0]    p_q [2];
  logic [AW-1:0]           addr_q [4];
  logic signed [WGT_W-1:0] wgt_q [4];
  logic [3:0]              vld_q;
  logic signed [ACC_W-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q [2];

  logic in_xfer, cfg_xfer, out_load;
  logic ram_we;
  logic [AW-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic signed [XW-1:0] wp_x, len_x, half_x;
  logic [AW-1:0]           tap_i [2];
  logic [AW-1:0]           tap_j [2];
  logic signed [WGT_W-1:0] tap_f [2];
  logic signed [WGT_W-1:0] tap_g [2];

  logic [2:0] mul_sel, acc_sel;
  logic signed [ACC_W-1:0] d_ext, w_ext;
  logic signed [PW-1:0] half_p, mod_l_p, mod_r_p;

  assign in_xfer  = in_valid && !in_stall;
  assign cfg_xfer = cfg_valid && cfg_ready;

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_xfer) state_next = ST_INDEX;
      ST_INDEX: state_next = ST_READ;
      ST_READ:  if (cnt == RD_CNT_LAST) state_next = ST_ROUND;
      ST_ROUND: if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs; a length write waits while a sample is offered
  always_comb begin
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = addr_q[cnt[1:0]];
    unique case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = !in_valid;
        ram_we    = in_valid;
      end
      ST_INDEX: ;
      ST_READ:  ;
      ST_ROUND: out_load = !out_valid || !out_stall;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // delay store
  dtmd_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DELAY_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp),
    .wdata(audio_in),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // displacement mod*offset, registered at the input transfer
  assign half_p  = $signed({{(PW-LEN_W+1){1'b0}}, len_eff[LEN_W-1:1]});
  assign mod_l_p = $signed({{(PW-MOD_W){mod_left[MOD_W-1]}}, mod_left});
  assign mod_r_p = $signed({{(PW-MOD_W){mod_right[MOD_W-1]}}, mod_right});

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      p_q[0] <= mod_l_p * half_p;
      p_q[1] <= mod_r_p * half_p;
    end
  end

  // tap index, neighbour and weights from the displacement
  assign wp_x   = $signed({{(XW-AW){1'b0}}, wp});
  assign len_x  = $signed({{(XW-LEN_W){1'b0}}, len_eff});
  assign half_x = $signed({{(XW-LEN_W+1){1'b0}}, len_eff[LEN_W-1:1]});

  always_comb begin : idx_calc
    logic signed [PW-1:0]    p;
    logic                    adj;
    logic signed [PW-1:0]    n;
    logic signed [XW-1:0]    idx;
    logic signed [WGT_W-1:0] f;
    p   = '0;
    adj = 1'b0;
    n   = '0;
    idx = '0;
    f   = '0;
    for (int t = 0; t < 2; t++) begin
      p   = p_q[t];
      // truncation toward zero: step up a negative value with a remainder
      adj = p[PW-1] && (p[Q15_W-1:0] != '0);
      n   = (p >>> Q15_W) + $signed({{(PW-1){1'b0}}, adj});
      f   = $signed({{(WGT_W-Q15_W){1'b0}}, p[Q15_W-1:0]}) - (adj ? Q15_ONE : '0);
      idx = wp_x - half_x - $signed(n[XW-1:0]);
      if (idx < 0) begin
        idx = idx + len_x;
      end
      tap_i[t] = idx[AW-1:0];
      tap_j[t] = (idx == len_x - ONE_X) ? '0 : idx[AW-1:0] + AW'(1);
      tap_f[t] = f;
      tap_g[t] = Q15_ONE - f;
    end
  end

  // tap registers in read order: left i, left j, right i, right j
  always_ff @(posedge clk) begin
    if (state == ST_INDEX) begin
      for (int t = 0; t < 2; t++) begin
        addr_q[2*t]     <= tap_i[t];
        addr_q[2*t+1]   <= tap_j[t];
        wgt_q[2*t]      <= tap_f[t];
        wgt_q[2*t+1]    <= tap_g[t];
        vld_q[2*t]      <= wrapped || (tap_i[t] <= wp);
        vld_q[2*t+1]    <= wrapped || (tap_j[t] <= wp);
      end
    end
  end

  // read phase counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == ST_READ) begin
      cnt <= cnt + 3'd1;
    end else begin
      cnt <= '0;
    end
  end

  // multiply the returned entry by its weight, then accumulate per tap
  assign mul_sel = cnt - 3'd1;
  assign acc_sel = cnt - 3'd2;
  assign d_ext = vld_q[mul_sel[1:0]]
               ? $signed({{(ACC_W-DATA_W){ram_rdata[DATA_W-1]}}, ram_rdata})
               : '0;
  assign w_ext = $signed({{(ACC_W-WGT_W){wgt_q[mul_sel[1:0]][WGT_W-1]}},
                          wgt_q[mul_sel[1:0]]});

  always_ff @(posedge clk) begin
    if (state == ST_READ && cnt >= 3'd1 && cnt <= RD_CNT_TAPS) begin
      prod_q <= d_ext * w_ext;
    end
    if (state == ST_READ && cnt >= 3'd2) begin
      if (!acc_sel[0]) begin
        acc_q[acc_sel[1]] <= prod_q;
      end else begin
        acc_q[acc_sel[1]] <= acc_q[acc_sel[1]] + prod_q;
      end
    end
  end

  // write pointer, written-region flag and length
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
      len_eff <= eff_length(LEN_RESET, DELAY_DEPTH);
    end else if (cfg_xfer) begin
      wp      <= '0;
      wrapped <= 1'b0;
      len_eff <= eff_length(cfg_data, DELAY_DEPTH);
    end else if (state == ST_INDEX) begin
      if (wp_x + ONE_X == len_x) begin
        wp      <= '0;
        wrapped <= 1'b1;
      end else begin
        wp <= wp + AW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      tap_left  <= round_sat(acc_q[0]);
      tap_right <= round_sat(acc_q[1]);
    end
  end

  // pointer stays inside the active length
  a_wp_range: assert property (@(posedge clk) disable iff (rst) wp_x < len_x)
    else $error("write pointer outside active length");

  // fixed schedule from input transfer to rounding stage
  a_schedule: assert property (@(posedge clk) disable iff (rst)
    in_xfer |-> ##8 (state == ST_ROUND))
    else $error("item did not reach rounding on schedule");

  // every tap address read lies inside the active length
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> ($signed({{(XW-AW){1'b0}}, addr_q[0]}) < len_x &&
                            $signed({{(XW-AW){1'b0}}, addr_q[1]}) < len_x &&
                            $signed({{(XW-AW){1'b0}}, addr_q[2]}) < len_x &&
                            $signed({{(XW-AW){1'b0}}, addr_q[3]}) < len_x))
    else $error("tap address outside active length");

endmodule
